[sv/pra_pkg.sv]
// Package with the shared sizes, field types and codes of the page run allocator.
package pra_pkg;

  localparam int NUM_PAGES  = 32;
  localparam int OWNER_BITS = 8;

  localparam int IDX_W = (NUM_PAGES > 2) ? $clog2(NUM_PAGES) : 1;
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  localparam int REQ_SIZE_W = 6;
  localparam int RUN_W = (CNT_W > REQ_SIZE_W) ? CNT_W : REQ_SIZE_W;

  typedef logic [1:0]            opcode_field_t;
  typedef logic [7:0]            owner_field_t;
  typedef logic [REQ_SIZE_W-1:0] size_field_t;
  typedef logic [1:0]            status_field_t;
  typedef logic [4:0]            start_field_t;
  typedef logic [5:0]            count_field_t;

  typedef logic [OWNER_BITS-1:0] tag_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_COMPACT = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD       = 2'd3
  } status_t;

endpackage

[sv/pra_if.sv]
// Request and response channel interfaces of the page run allocator.
interface pra_req_if;
  import pra_pkg::*;

  logic          valid;
  logic          ready;
  opcode_field_t opcode;
  owner_field_t  owner;
  size_field_t   request_size;

  modport source (output valid, output opcode, output owner, output request_size,
                  input ready);
  modport sink (input valid, input opcode, input owner, input request_size,
                output ready);
endinterface

interface pra_rsp_if;
  import pra_pkg::*;

  logic          valid;
  logic          ready;
  status_field_t status;
  start_field_t  start_page;
  count_field_t  page_count;
  count_field_t  free_pages;

  modport source (output valid, output status, output start_page, output page_count,
                  output free_pages, input ready);
  modport sink (input valid, input status, input start_page, input page_count,
                input free_pages, output ready);
endinterface

[sv/page_run_allocator_core.sv]
// Top level of the page run allocator: owner-tag memory, sequencer and result register.
//
// The block keeps one owner tag per page in a synchronous memory; tag zero
// marks a free page. Requests arrive on the req channel (opcode, owner,
// request_size) and each produces exactly one transfer on the rsp channel
// (status, start_page, page_count, free_pages). A transfer happens on a
// rising clock edge where valid and ready are both high.
//
// Allocate, free and compact sweep the memory one page per cycle through the
// registered read port. Allocate stops scanning at the first fitting run and
// then writes request_size pages, one per cycle. Rejected requests skip the
// sweep and go straight to the done state, where their result is loaded.
//
// Reset clears the per-page valid flags, so every page reads as free at once,
// and sets the free-page count to NUM_PAGES. A result waits in the output
// register while the receiver stalls; the next request is still accepted
// and worked on, and it only waits at the end for the register to drain.
module page_run_allocator_core (
  input  logic           clk,
  input  logic           rst,
  pra_req_if.sink        req,
  pra_rsp_if.source      rsp
);
  import pra_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_DONE
  } state_t;

  // Owner-tag memory with one write port and one registered read port.
  tag_t                 page_mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] page_valid;
  logic [NUM_PAGES-1:0] page_valid_next;
  tag_t                 mem_rdata;
  logic                 rd_valid;
  logic [IDX_W-1:0]     mem_raddr;
  logic [IDX_W-1:0]     mem_waddr;
  tag_t                 mem_wdata;
  logic                 mem_we;
  logic                 trim;

  // Sequencer registers.
  state_t           state, state_next;
  opcode_t          op, op_next;
  tag_t             tag, tag_next;
  size_field_t      want, want_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             pend, pend_next;
  logic [IDX_W-1:0] paddr, paddr_next;
  logic [RUN_W-1:0] run, run_next;
  logic [IDX_W-1:0] run_start, run_start_next;
  logic [CNT_W-1:0] wptr, wptr_next;
  logic [RUN_W-1:0] fill_left, fill_left_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] free_cnt, free_cnt_next;
  status_t          res_status, res_status_next;
  logic [IDX_W-1:0] res_start, res_start_next;
  logic [CNT_W-1:0] res_count, res_count_next;

  // Output register.
  logic          out_valid;
  status_field_t out_status;
  start_field_t  out_start;
  count_field_t  out_count;
  count_field_t  out_free;

  tag_t             page_data;
  tag_t             req_tag;
  logic             accept;
  logic             out_load;
  logic             last_page;
  logic [RUN_W-1:0] run_inc;
  logic [IDX_W-1:0] run_start_eff;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  // The stored tag is the owner masked to the tag width.
  assign req_tag   = OWNER_BITS'(req.owner);
  // A page never written since reset or trimmed by compaction reads as free.
  assign page_data = rd_valid ? mem_rdata : '0;
  assign last_page = (paddr == IDX_W'(NUM_PAGES - 1));
  assign run_inc   = run + RUN_W'(1);
  assign run_start_eff = (run == '0) ? paddr : run_start;

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.start_page = out_start;
  assign rsp.page_count = out_count;
  assign rsp.free_pages = out_free;

  always_comb begin
    state_next      = state;
    op_next         = op;
    tag_next        = tag;
    want_next       = want;
    idx_next        = idx;
    pend_next       = 1'b0;
    paddr_next      = paddr;
    run_next        = run;
    run_start_next  = run_start;
    wptr_next       = wptr;
    fill_left_next  = fill_left;
    cnt_next        = cnt;
    free_cnt_next   = free_cnt;
    res_status_next = res_status;
    res_start_next  = res_start;
    res_count_next  = res_count;
    mem_raddr       = idx[IDX_W-1:0];
    mem_waddr       = wptr[IDX_W-1:0];
    mem_wdata       = tag;
    mem_we          = 1'b0;
    trim            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_next         = opcode_t'(req.opcode);
          tag_next        = req_tag;
          want_next       = req.request_size;
          idx_next        = '0;
          run_next        = '0;
          wptr_next       = '0;
          cnt_next        = '0;
          res_status_next = ST_OK;
          res_start_next  = '0;
          res_count_next  = '0;
          unique case (opcode_t'(req.opcode))
            OP_ALLOC: begin
              if (req_tag == '0 || req.request_size == '0) begin
                res_status_next = ST_BAD;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_FREE: begin
              if (req_tag == '0) begin
                res_status_next = ST_BAD;
                state_next      = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            OP_COMPACT: state_next = S_SCAN;
            default: begin
              res_status_next = ST_BAD;
              state_next      = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous page's data is processed.
        if (idx < CNT_W'(NUM_PAGES)) begin
          idx_next   = idx + CNT_W'(1);
          pend_next  = 1'b1;
          paddr_next = idx[IDX_W-1:0];
        end
        if (pend) begin
          unique case (op)
            OP_ALLOC: begin
              if (page_data == '0) begin
                run_next       = run_inc;
                run_start_next = run_start_eff;
                if (run_inc >= RUN_W'(want)) begin
                  // First fit found: tag the run from its start.
                  wptr_next      = CNT_W'(run_start_eff);
                  fill_left_next = RUN_W'(want);
                  pend_next      = 1'b0;
                  state_next     = S_FILL;
                end else if (last_page) begin
                  res_status_next = ST_NO_SPACE;
                  state_next      = S_DONE;
                end
              end else begin
                run_next = '0;
                if (last_page) begin
                  res_status_next = ST_NO_SPACE;
                  state_next      = S_DONE;
                end
              end
            end
            OP_FREE: begin
              if (page_data == tag) begin
                mem_we    = 1'b1;
                mem_waddr = paddr;
                mem_wdata = '0;
                cnt_next  = cnt + CNT_W'(1);
              end
              if (last_page) begin
                free_cnt_next   = free_cnt + cnt_next;
                res_count_next  = cnt_next;
                res_status_next = (cnt_next == '0) ? ST_NOT_FOUND : ST_OK;
                state_next      = S_DONE;
              end
            end
            default: begin
              // Compaction: used pages are copied down to the write pointer,
              // which never passes the read address.
              if (page_data != '0) begin
                mem_we    = 1'b1;
                mem_waddr = wptr[IDX_W-1:0];
                mem_wdata = page_data;
                wptr_next = wptr + CNT_W'(1);
              end
              if (last_page) begin
                trim       = 1'b1;
                state_next = S_DONE;
              end
            end
          endcase
        end
      end

      S_FILL: begin
        mem_we         = 1'b1;
        mem_waddr      = wptr[IDX_W-1:0];
        mem_wdata      = tag;
        wptr_next      = wptr + CNT_W'(1);
        fill_left_next = fill_left - RUN_W'(1);
        if (fill_left == RUN_W'(1)) begin
          free_cnt_next   = free_cnt - CNT_W'(want);
          res_status_next = ST_OK;
          res_start_next  = run_start;
          res_count_next  = CNT_W'(want);
          state_next      = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Valid flags: a write marks its page; trimming after compaction drops
  // every page at or above the final write pointer.
  always_comb begin
    page_valid_next = page_valid;
    if (mem_we) begin
      page_valid_next[mem_waddr] = 1'b1;
    end
    if (trim) begin
      for (int j = 0; j < NUM_PAGES; j++) begin
        if (CNT_W'(j) >= wptr_next) begin
          page_valid_next[j] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= page_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      page_valid <= '0;
      rd_valid   <= 1'b0;
      pend       <= 1'b0;
      free_cnt   <= CNT_W'(NUM_PAGES);
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      page_valid <= page_valid_next;
      rd_valid   <= page_valid[mem_raddr];
      pend       <= pend_next;
      free_cnt   <= free_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    op         <= op_next;
    tag        <= tag_next;
    want       <= want_next;
    idx        <= idx_next;
    paddr      <= paddr_next;
    run        <= run_next;
    run_start  <= run_start_next;
    wptr       <= wptr_next;
    fill_left  <= fill_left_next;
    cnt        <= cnt_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
    res_count  <= res_count_next;
    if (out_load) begin
      out_status <= res_status;
      out_start  <= 5'(res_start);
      out_count  <= 6'(res_count);
      out_free   <= 6'(free_cnt);
    end
  end

endmodule
